FILE: hw/rtl/ecd_pkg.sv
// Package for the epoch time to civil date/time converter.
// Holds constants, unit tables, stage side-band types and the result record.
// No dependencies.
package ecd_pkg;

  localparam int MAG_W  = 63;
  localparam int FRAC_W = 30;
  localparam int SOD_W  = 17;
  localparam int ERA_W  = 18;
  localparam int RCP_W  = 55;

  localparam logic [SOD_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [ERA_W-1:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [19:0]      EPOCH_SHIFT  = 20'd719468;

  // Reciprocals are floor(2^64 / divisor); no divisor here is a power of two.
  localparam logic [63:0]      RCP_NUM   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [RCP_W-1:0] DAY_RECIP = RCP_W'(RCP_NUM / 64'd86400);
  localparam logic [RCP_W-1:0] ERA_RECIP = RCP_W'(RCP_NUM / 64'd146097);

  typedef enum logic {
    KIND_DATE  = 1'b0,
    KIND_STAMP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    UNIT_SEC   = 2'd0,
    UNIT_MILLI = 2'd1,
    UNIT_MICRO = 2'd2,
    UNIT_NANO  = 2'd3
  } unit_t;

  typedef struct packed {
    kind_t kind;
    unit_t unit;
    logic  neg;
  } side1_t;

  typedef struct packed {
    kind_t             kind;
    unit_t             unit;
    logic              neg;
    logic [FRAC_W-1:0] frac;
  } side2_t;

  typedef struct packed {
    kind_t             kind;
    unit_t             unit;
    logic              neg;
    logic [FRAC_W-1:0] frac;
    logic [SOD_W-1:0]  sod;
  } side3_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] frac_ns;
    logic [2:0]  digits;
    logic [4:0]  width;
    logic        wrapped;
  } result_t;

  function automatic logic [FRAC_W-1:0] unit_per_sec(unit_t u);
    case (u)
      UNIT_SEC:   return 30'd1;
      UNIT_MILLI: return 30'd1000;
      UNIT_MICRO: return 30'd1000000;
      UNIT_NANO:  return 30'd1000000000;
      default:    return 30'd1;
    endcase
  endfunction

  // A divisor of one bypasses the multiply, so seconds need no reciprocal.
  function automatic logic [RCP_W-1:0] unit_recip(unit_t u);
    case (u)
      UNIT_SEC:   return '0;
      UNIT_MILLI: return RCP_W'(RCP_NUM / 64'd1000);
      UNIT_MICRO: return RCP_W'(RCP_NUM / 64'd1000000);
      UNIT_NANO:  return RCP_W'(RCP_NUM / 64'd1000000000);
      default:    return '0;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] unit_ns_mul(unit_t u);
    case (u)
      UNIT_SEC:   return 30'd1000000000;
      UNIT_MILLI: return 30'd1000000;
      UNIT_MICRO: return 30'd1000;
      UNIT_NANO:  return 30'd1;
      default:    return 30'd1;
    endcase
  endfunction

  function automatic logic [2:0] unit_digits(unit_t u);
    case (u)
      UNIT_SEC:   return 3'd0;
      UNIT_MILLI: return 3'd3;
      UNIT_MICRO: return 3'd6;
      UNIT_NANO:  return 3'd7;
      default:    return 3'd0;
    endcase
  endfunction

  // First day of each March-based month within the year.
  function automatic logic [8:0] month_start(logic [3:0] mp);
    case (mp)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/epoch_time_to_civil_datetime_unit.sv
// Top level of the epoch time to civil date/time converter.
// Depends on ecd_pkg, ecd_div_pipe and ecd_civil.

// Takes one transfer per cycle unless the pipeline is held, and returns one
// result transfer per input, in order. It chains three reciprocal-multiply
// dividers of six stages each (unit, seconds per day, days per 400-year era),
// followed by seven stages of civil-date arithmetic whose last is the output
// register. The whole pipeline holds while a result waits on m_tready.
module epoch_time_to_civil_datetime_unit import ecd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // value
  input  logic [2:0]  s_tuser,  // kind, unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // year, month, day_of_month, hour, minute, second,
                                // fraction_ns, fraction_digits, column_width
  output logic [0:0]  m_tuser   // year_wrapped
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  kind_t            in_kind;
  unit_t            in_unit;
  logic             in_neg;
  logic [MAG_W-1:0] in_mag;
  logic [FRAC_W-1:0] in_div;
  logic [RCP_W-1:0] in_recip;
  side1_t           in_side;

  assign in_kind  = kind_t'(s_tuser[0]);
  assign in_unit  = unit_t'(s_tuser[2:1]);
  assign in_neg   = s_tdata[63];
  assign in_mag   = s_tdata[62:0] ^ {MAG_W{in_neg}};
  assign in_div   = (in_kind == KIND_STAMP) ? unit_per_sec(in_unit) : 30'd1;
  assign in_recip = (in_kind == KIND_STAMP) ? unit_recip(in_unit) : '0;
  assign in_side  = '{kind: in_kind, unit: in_unit, neg: in_neg};

  logic              v1;
  logic [MAG_W-1:0]  q1;
  logic [FRAC_W-1:0] r1;
  side1_t            s1;

  ecd_div_pipe #(.W(MAG_W), .DW(FRAC_W), .RW(RCP_W), .SW($bits(side1_t))) u_div_unit (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && en), .dividend(in_mag), .divisor(in_div), .recip(in_recip),
    .side_in(in_side),
    .out_valid(v1), .quot(q1), .rem(r1), .side_out(s1)
  );

  logic [FRAC_W-1:0] d1;
  logic [SOD_W-1:0]  d2_in;
  logic [RCP_W-1:0]  recip2_in;
  side2_t            side2_in;

  assign d1        = (s1.kind == KIND_STAMP) ? unit_per_sec(s1.unit) : 30'd1;
  assign d2_in     = (s1.kind == KIND_STAMP) ? SEC_PER_DAY : 17'd1;
  assign recip2_in = (s1.kind == KIND_STAMP) ? DAY_RECIP : '0;
  assign side2_in  = '{kind: s1.kind, unit: s1.unit, neg: s1.neg,
                       frac: s1.neg ? (d1 - 30'd1 - r1) : r1};

  logic             v2;
  logic [MAG_W-1:0] q2;
  logic [SOD_W-1:0] r2;
  side2_t           s2;

  ecd_div_pipe #(.W(MAG_W), .DW(SOD_W), .RW(RCP_W), .SW($bits(side2_t))) u_div_day (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .dividend(q1), .divisor(d2_in), .recip(recip2_in),
    .side_in(side2_in),
    .out_valid(v2), .quot(q2), .rem(r2), .side_out(s2)
  );

  logic [SOD_W-1:0] d2;
  side3_t           side3_in;

  assign d2       = (s2.kind == KIND_STAMP) ? SEC_PER_DAY : 17'd1;
  assign side3_in = '{kind: s2.kind, unit: s2.unit, neg: s2.neg, frac: s2.frac,
                      sod: s2.neg ? (d2 - 17'd1 - r2) : r2};

  logic             v3;
  logic [MAG_W-1:0] q3;
  logic [ERA_W-1:0] r3;
  side3_t           s3;

  ecd_div_pipe #(.W(MAG_W), .DW(ERA_W), .RW(RCP_W), .SW($bits(side3_t))) u_div_era (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .dividend(q2), .divisor(DAYS_PER_ERA), .recip(ERA_RECIP),
    .side_in(side3_in),
    .out_valid(v3), .quot(q3), .rem(r3), .side_out(s3)
  );

  result_t res;

  ecd_civil u_civil (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .qmag(q3), .rmag(r3), .side(s3),
    .out_valid(m_tvalid), .res(res)
  );

  assign m_tdata = {res.width, res.digits, res.frac_ns, res.second, res.minute,
                    res.hour, res.mday, res.month, res.year};
  assign m_tuser = res.wrapped;

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.month >= 4'd1 && res.month <= 4'd12 && res.mday >= 5'd1))
    else $error("month or day out of range");

  a_width_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.digits == 3'd0 |-> (res.width == 5'd0 || res.width == 5'd19))
    else $error("column width does not match digit count");

  a_date_zero_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.width == 5'd0 |->
      (res.hour == 5'd0 && res.minute == 6'd0 && res.second == 6'd0 &&
       res.frac_ns == 30'd0))
    else $error("date result carries a time of day");

endmodule

FILE: hw/rtl/ecd_div_pipe.sv
// Pipelined divider by a per-item constant: reciprocal multiply, one correction
// step, six register stages. Carries a side-band word with each item. No dependencies.
module ecd_div_pipe #(
  parameter int W  = 63,
  parameter int DW = 30,
  parameter int RW = 55,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  input  logic [RW-1:0] recip,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quot,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  localparam int XH  = W - 32;
  localparam int MH  = RW - 32;
  localparam int PW  = W + RW;
  localparam int AW  = 32 + MH;
  localparam int BW  = XH + 32;
  localparam int CW  = XH + MH;
  localparam int MW  = PW - 32;
  localparam int QAW = 32 + DW;
  localparam int QBW = XH + DW;
  localparam int NW  = DW + 1;

  logic [5:0] vld;

  logic [W-1:0]  x1, x2, x3, x4, x5;
  logic [DW-1:0] d1, d2, d3, d4, d5;
  logic          one1, one2, one3, one4, one5;
  logic [SW-1:0] s1, s2, s3, s4, s5;

  logic [63:0]    pp0;
  logic [AW-1:0]  pp1;
  logic [BW-1:0]  pp2;
  logic [CW-1:0]  pp3;
  logic [63:0]    lo2;
  logic [MW-1:0]  mid2;
  logic [CW-1:0]  hi2;
  logic [W-1:0]   q3, q4, q5;
  logic [QAW-1:0] qa4;
  logic [QBW-1:0] qb4;
  logic [NW-1:0]  r5;

  logic [PW-1:0] prod_c;
  logic [63:0]   qd_c;
  logic          ge_c;

  // The estimate floor(x * recip / 2^64) is the quotient or one below it.
  always_comb begin
    prod_c = {hi2, 64'b0} + {mid2, 32'b0} + PW'(lo2);
    qd_c   = 64'({qb4, 32'b0}) + 64'(qa4);
    ge_c   = r5 >= {1'b0, d5};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= dividend;
      d1   <= divisor;
      one1 <= divisor == DW'(1);
      s1   <= side_in;
      pp0  <= {32'b0, dividend[31:0]} * {32'b0, recip[31:0]};
      pp1  <= AW'(dividend[31:0]) * AW'(recip[RW-1:32]);
      pp2  <= BW'(dividend[W-1:32]) * BW'(recip[31:0]);
      pp3  <= CW'(dividend[W-1:32]) * CW'(recip[RW-1:32]);

      x2   <= x1;
      d2   <= d1;
      one2 <= one1;
      s2   <= s1;
      lo2  <= pp0;
      mid2 <= MW'(pp1) + MW'(pp2);
      hi2  <= pp3;

      x3   <= x2;
      d3   <= d2;
      one3 <= one2;
      s3   <= s2;
      q3   <= W'(prod_c[PW-1:64]);

      x4   <= x3;
      d4   <= d3;
      one4 <= one3;
      s4   <= s3;
      q4   <= q3;
      qa4  <= QAW'(q3[31:0]) * QAW'(d3);
      qb4  <= QBW'(q3[W-1:32]) * QBW'(d3);

      x5   <= x4;
      d5   <= d4;
      one5 <= one4;
      s5   <= s4;
      q5   <= q4;
      r5   <= NW'(64'(x4) - qd_c);

      quot     <= one5 ? x5 : q5 + W'(ge_c);
      rem      <= one5 ? '0 : (ge_c ? DW'(r5 - {1'b0, d5}) : r5[DW-1:0]);
      side_out <= s5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  assign out_valid = vld[5];

endmodule

FILE: hw/rtl/ecd_civil.sv
// Civil-from-days and time-of-day pipeline, seven register stages.
// The last stage is the output register. Depends on ecd_pkg.
module ecd_civil import ecd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] qmag,
  input  logic [ERA_W-1:0] rmag,
  input  side3_t           side,
  output logic             out_valid,
  output result_t          res
);

  localparam logic [20:0] HOUR_RECIP = 21'd1193047;
  localparam logic [17:0] Y1460_RCP  = 18'd183860;
  localparam logic [17:0] Y365_RCP   = 18'd183860;
  localparam logic [14:0] MIN_RECIP  = 15'd17477;
  localparam logic [11:0] MP_RECIP   = 12'd3427;

  logic v1, v2, v3, v4, v5, v6, v7;

  // Stage 1
  kind_t       kind1;
  unit_t       unit1;
  logic [63:0] q1;
  logic [19:0] s1;
  logic [37:0] hp1;
  logic [16:0] sod1;
  logic [29:0] fr1;

  logic [63:0] q_c;
  logic [17:0] r_c;
  logic [37:0] hp_c;
  logic [59:0] fp_c;

  always_comb begin
    q_c  = side.neg ? ~{1'b0, qmag} : {1'b0, qmag};
    r_c  = side.neg ? 18'(DAYS_PER_ERA - 18'd1 - rmag) : rmag;
    hp_c = {21'b0, side.sod} * {17'b0, HOUR_RECIP};
    fp_c = {30'b0, side.frac} * {30'b0, unit_ns_mul(side.unit)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1 <= side.kind;
      unit1 <= side.unit;
      q1    <= q_c;
      s1    <= {2'b0, r_c} + EPOCH_SHIFT;
      hp1   <= hp_c;
      sod1  <= side.sod;
      fr1   <= fp_c[29:0];
    end
  end

  // Stage 2
  kind_t       kind2;
  unit_t       unit2;
  logic [63:0] era2;
  logic [17:0] doe2;
  logic [4:0]  hour2;
  logic [11:0] hrem2;
  logic [29:0] fr2;

  logic [2:0] inc_c;
  logic [4:0] hour_c;

  always_comb begin
    inc_c = '0;
    for (int k = 1; k <= 5; k++) begin
      if (s1 >= 20'(k * 146097)) begin
        inc_c = inc_c + 3'd1;
      end
    end
    hour_c = hp1[36:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2 <= kind1;
      unit2 <= unit1;
      era2  <= q1 + {61'b0, inc_c};
      doe2  <= 18'(s1 - 20'(inc_c) * {2'b0, DAYS_PER_ERA});
      hour2 <= hour_c;
      hrem2 <= 12'(sod1 - 17'(hour_c) * 17'd3600);
      fr2   <= fr1;
    end
  end

  // Stage 3
  kind_t       kind3;
  unit_t       unit3;
  logic [63:0] era400_3;
  logic [17:0] doe3;
  logic [6:0]  n1460_3;
  logic [2:0]  n36524_3;
  logic        nlast_3;
  logic [26:0] mprod3;
  logic [11:0] hrem3;
  logic [4:0]  hour3;
  logic [29:0] fr3;

  logic [35:0] p1460_c;
  logic [2:0]  c36524_c;

  always_comb begin
    p1460_c  = {18'b0, doe2} * {18'b0, Y1460_RCP};
    c36524_c = '0;
    for (int k = 1; k <= 4; k++) begin
      if (doe2 >= 18'(k * 36524)) begin
        c36524_c = c36524_c + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind3    <= kind2;
      unit3    <= unit2;
      era400_3 <= (era2 << 8) + (era2 << 7) + (era2 << 4);
      doe3     <= doe2;
      n1460_3  <= p1460_c[34:28];
      n36524_3 <= c36524_c;
      nlast_3  <= doe2 == 18'd146096;
      mprod3   <= {15'b0, hrem2} * {12'b0, MIN_RECIP};
      hrem3    <= hrem2;
      hour3    <= hour2;
      fr3      <= fr2;
    end
  end

  // Stage 4
  kind_t       kind4;
  unit_t       unit4;
  logic [63:0] era400_4;
  logic [17:0] doe4;
  logic [35:0] yprod4;
  logic [4:0]  hour4;
  logic [5:0]  minute4;
  logic [5:0]  second4;
  logic [29:0] fr4;

  logic [17:0] x_c;
  logic [5:0]  minute_c;

  always_comb begin
    x_c      = doe3 - 18'(n1460_3) + 18'(n36524_3) - 18'(nlast_3);
    minute_c = mprod3[25:20];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind4    <= kind3;
      unit4    <= unit3;
      era400_4 <= era400_3;
      doe4     <= doe3;
      yprod4   <= {18'b0, x_c} * {18'b0, Y365_RCP};
      hour4    <= hour3;
      minute4  <= minute_c;
      second4  <= 6'(hrem3 - 12'(minute_c) * 12'd60);
      fr4      <= fr3;
    end
  end

  // Stage 5
  kind_t       kind5;
  unit_t       unit5;
  logic [63:0] era400_5;
  logic [8:0]  yoe5;
  logic [8:0]  doy5;
  logic [4:0]  hour5;
  logic [5:0]  minute5;
  logic [5:0]  second5;
  logic [29:0] fr5;

  logic [8:0]  yoe_c;
  logic [1:0]  c100_c;
  logic [17:0] ystart_c;

  always_comb begin
    yoe_c  = yprod4[34:26];
    c100_c = '0;
    for (int k = 1; k <= 3; k++) begin
      if (yoe_c >= 9'(k * 100)) begin
        c100_c = c100_c + 2'd1;
      end
    end
    ystart_c = 18'(yoe_c) * 18'd365 + 18'(yoe_c[8:2]) - 18'(c100_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind5    <= kind4;
      unit5    <= unit4;
      era400_5 <= era400_4;
      yoe5     <= yoe_c;
      doy5     <= 9'(doe4 - ystart_c);
      hour5    <= hour4;
      minute5  <= minute4;
      second5  <= second4;
      fr5      <= fr4;
    end
  end

  // Stage 6
  kind_t       kind6;
  unit_t       unit6;
  logic [63:0] ybase6;
  logic [8:0]  doy6;
  logic [3:0]  mp6;
  logic [4:0]  hour6;
  logic [5:0]  minute6;
  logic [5:0]  second6;
  logic [29:0] fr6;

  logic [10:0] y5_c;
  logic [22:0] mpp_c;

  always_comb begin
    y5_c  = 11'(doy5) * 11'd5 + 11'd2;
    mpp_c = {12'b0, y5_c} * {11'b0, MP_RECIP};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind6   <= kind5;
      unit6   <= unit5;
      ybase6  <= era400_5 + {55'b0, yoe5};
      doy6    <= doy5;
      mp6     <= mpp_c[22:19];
      hour6   <= hour5;
      minute6 <= minute5;
      second6 <= second5;
      fr6     <= fr5;
    end
  end

  // Stage 7: output register
  logic [3:0]  mo_c;
  logic [63:0] year_c;
  logic [2:0]  dig_c;
  logic [4:0]  wid_c;

  always_comb begin
    mo_c   = (mp6 < 4'd10) ? mp6 + 4'd3 : mp6 - 4'd9;
    year_c = ybase6 + {63'b0, (mp6 >= 4'd10)};
    dig_c  = (kind6 == KIND_STAMP) ? unit_digits(unit6) : 3'd0;
    if (kind6 == KIND_DATE) begin
      wid_c = 5'd0;
    end else if (dig_c == 3'd0) begin
      wid_c = 5'd19;
    end else begin
      wid_c = 5'd20 + 5'(dig_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.year    <= year_c[15:0];
      res.month   <= mo_c;
      res.mday    <= 5'(doy6 - month_start(mp6) + 9'd1);
      res.hour    <= hour6;
      res.minute  <= minute6;
      res.second  <= second6;
      res.frac_ns <= fr6;
      res.digits  <= dig_c;
      res.width   <= wid_c;
      res.wrapped <= !((&year_c[63:15]) || !(|year_c[63:15]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  assign out_valid = v7;

endmodule

FILE: tb/epoch_time_to_civil_datetime_unit_test.sv
// Self-checking bench for epoch_time_to_civil_datetime_unit: directed edge values, then random
// day counts and timestamps in every unit, checked against an in-bench civil date predictor.
// Depends on ecd_pkg and the converter RTL.
module epoch_time_to_civil_datetime_unit_test;
  import ecd_pkg::*;

  class civil_ledger;
    result_t pending_q[$];
    int mismatches;
    int matched;

    function automatic longint floor_div(longint v, longint d, output longint r);
      longint q;
      q = v / d;
      r = v % d;
      if (r < 0) begin
        r += d;
        q -= 1;
      end
      return q;
    endfunction

    function automatic void note(kind_t kind, unit_t unit, longint v);
      result_t e;
      longint days, secs, frac, sod, q, r, s, era, yr;
      longint per_sec, ns_mul, doe, yoe, doy, mp, mo;
      e = '0;
      if (kind == KIND_DATE) begin
        days = v;
      end else begin
        case (unit)
          UNIT_SEC: begin per_sec = 1; ns_mul = 1000000000; e.digits = 3'd0; end
          UNIT_MILLI: begin per_sec = 1000; ns_mul = 1000000; e.digits = 3'd3; end
          UNIT_MICRO: begin per_sec = 1000000; ns_mul = 1000; e.digits = 3'd6; end
          default: begin per_sec = 1000000000; ns_mul = 1; e.digits = 3'd7; end
        endcase
        secs = floor_div(v, per_sec, frac);
        days = floor_div(secs, 86400, sod);
        e.hour = 5'(sod / 3600);
        e.minute = 6'((sod % 3600) / 60);
        e.second = 6'(sod % 60);
        e.frac_ns = 30'(frac * ns_mul);
        e.width = (e.digits != 0) ? 5'(20 + e.digits) : 5'd19;
      end
      q = floor_div(days, 146097, r);
      s = r + 719468;
      era = q + s / 146097;
      doe = s % 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      mo = (mp < 10) ? mp + 3 : mp - 9;
      yr = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
      e.mday = 5'(doy - (153 * mp + 2) / 5 + 1);
      e.month = 4'(mo);
      e.year = 16'(yr);
      e.wrapped = (yr < -32768 || yr > 32767);
      pending_q.push_back(e);
    endfunction

    function automatic void check(logic [79:0] data, logic wrapped);
      result_t got, e;
      got.year = data[15:0];
      got.month = data[19:16];
      got.mday = data[24:20];
      got.hour = data[29:25];
      got.minute = data[35:30];
      got.second = data[41:36];
      got.frac_ns = data[71:42];
      got.digits = data[74:72];
      got.width = data[79:75];
      got.wrapped = wrapped;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected y=%0d m=%0d d=%0d %0d:%0d:%0d ns=%0d dg=%0d w=%0d wr=%0b,",
                   $signed(e.year), e.month, e.mday, e.hour, e.minute, e.second, e.frac_ns,
                   e.digits, e.width, e.wrapped,
                   " got y=%0d m=%0d d=%0d %0d:%0d:%0d ns=%0d dg=%0d w=%0d wr=%0b",
                   $signed(got.year), got.month, got.mday, got.hour, got.minute,
                   got.second, got.frac_ns, got.digits, got.width, got.wrapped);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // value
  logic [2:0] s_tuser = '0;   // kind, unit
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;       // year, month, day_of_month, hour, minute, second,
                              // fraction_ns, fraction_digits, column_width
  logic [0:0] m_tuser;        // year_wrapped

  civil_ledger ledger = new();
  bit quiet = 1'b0;
  int sent = 0;
  int stall_left = 0;

  epoch_time_to_civil_datetime_unit uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check(m_tdata, m_tuser[0]);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 16) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(kind_t kind, unit_t unit, longint v);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= {unit, kind};
    do @(posedge clk); while (!s_tready);
    ledger.note(kind, unit, v);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic longint pick_value();
    longint v;
    case ($urandom_range(0, 4))
      0: v = {$urandom(), $urandom()};
      1: v = longint'($urandom_range(0, 6000000)) - 3000000;
      2: v = {{24{$urandom_range(0, 1) == 1}}, 8'($urandom()), $urandom()};
      3: v = longint'($signed({$urandom(), 12'($urandom())})) * 86400;
      default: v = {{4{$urandom_range(0, 1) == 1}}, 28'($urandom()), $urandom()};
    endcase
    return v;
  endfunction

  initial begin
    longint extremes[$];
    longint mx, mn;
    mx = 64'h7fff_ffff_ffff_ffff;
    mn = 64'h8000_0000_0000_0000;
    extremes = '{0, -1, 1, mx, mn, -719468, 11016, 11017};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (extremes[i]) send_item(KIND_DATE, UNIT_SEC, extremes[i]);
    send_item(KIND_DATE, UNIT_NANO, 60);
    for (int u = 0; u < 4; u++) begin
      send_item(KIND_STAMP, unit_t'(u), 0);
      send_item(KIND_STAMP, unit_t'(u), -1);
      send_item(KIND_STAMP, unit_t'(u), mx);
      send_item(KIND_STAMP, unit_t'(u), mn);
    end
    for (int i = 0; i < 500; i++) begin
      if (i == 250) begin
        s_tvalid <= 1'b0;
        while (ledger.pending_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (i == 420) quiet = 1'b1;
      send_item(kind_t'($urandom_range(0, 1)), unit_t'($urandom_range(0, 3)), pick_value());
    end
    s_tvalid <= 1'b0;
    while (ledger.pending_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Sent %0d dates and timestamps across all units and the full 64-bit range;",
             sent);
    $display("%0d results matched, %0d mismatched.", ledger.matched, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Timed out with %0d results outstanding.", ledger.pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
